### hdl/vsfs_pkg.sv
package vsfs_pkg;

   localparam int STRIP_COUNT_DEF      = 7;
   localparam int PIXELS_PER_STRIP_DEF = 128;

   localparam int COORD_W   = 7;
   localparam int TIME_W    = 16;
   localparam int CH_W      = 8;
   localparam int STRIP_W   = 4;
   localparam int SUM_W     = 16;
   localparam int ROOT_W    = 16;
   localparam int NUM_W     = 23;
   localparam int SCALE_W   = 17;
   localparam int COLOUR_W  = 3 * CH_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPHERE_RADIUS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELAPSED_TIME  = 3'd4;

   localparam logic [COORD_W-1:0] RADIUS_RESET = 7'd16;

   // Reciprocal of the ramp step length: floor(n / 1000) == (n * RECIP) >> RECIP_SHIFT
   // for every n below 2^18.
   localparam logic [18:0] RECIP       = 19'd268436;
   localparam int          RECIP_SHIFT = 28;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

endpackage

### hdl/vsfs_ram.sv
module vsfs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 896
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/vsfs_ramp.sv
module vsfs_ramp
   import vsfs_pkg::*;
(
   input  logic              clock,
   input  logic [TIME_W-1:0] elapsed_time,
   output rgb_type           base
);

   localparam logic [2:0] SEG_RED_YELLOW   = 3'd0;
   localparam logic [2:0] SEG_YELLOW_GREEN = 3'd1;
   localparam logic [2:0] SEG_GREEN_CYAN   = 3'd2;
   localparam logic [2:0] SEG_CYAN_BLUE    = 3'd3;
   localparam logic [2:0] SEG_BLUE_MAGENTA = 3'd4;
   localparam logic [2:0] SEG_MAGENTA_RED  = 3'd5;
   localparam logic [2:0] SEG_WHITE        = 3'd6;

   logic [2:0]  seg_in, seg_ff;
   logic [9:0]  pos_in, pos_ff;
   logic        round_up;
   logic [17:0] numer;
   logic [36:0] prod;
   logic [7:0]  quot, down;
   rgb_type     base_in, base_ff;

   always_comb begin
      if (elapsed_time < 16'd1000) begin
         seg_in = SEG_RED_YELLOW;
         pos_in = elapsed_time[9:0];
      end else if (elapsed_time < 16'd2000) begin
         seg_in = SEG_YELLOW_GREEN;
         pos_in = 10'(elapsed_time - 16'd1000);
      end else if (elapsed_time < 16'd3000) begin
         seg_in = SEG_GREEN_CYAN;
         pos_in = 10'(elapsed_time - 16'd2000);
      end else if (elapsed_time < 16'd4000) begin
         seg_in = SEG_CYAN_BLUE;
         pos_in = 10'(elapsed_time - 16'd3000);
      end else if (elapsed_time < 16'd5000) begin
         seg_in = SEG_BLUE_MAGENTA;
         pos_in = 10'(elapsed_time - 16'd4000);
      end else if (elapsed_time <= 16'd6000) begin
         seg_in = SEG_MAGENTA_RED;
         pos_in = 10'(elapsed_time - 16'd5000);
      end else begin
         seg_in = SEG_WHITE;
         pos_in = 10'd0;
      end
   end

   // Falling segments round the step up, rising ones round it down.
   always_comb begin
      round_up = (seg_ff == SEG_YELLOW_GREEN) || (seg_ff == SEG_CYAN_BLUE) ||
                 (seg_ff == SEG_MAGENTA_RED);
      numer    = 18'(pos_ff) * 18'd255 + (round_up ? 18'd999 : 18'd0);
      prod     = 37'(numer) * 37'(RECIP);
      quot     = prod[RECIP_SHIFT+7:RECIP_SHIFT];
      down     = 8'd255 - quot;
      case (seg_ff)
         SEG_RED_YELLOW:   base_in = '{8'd255, quot,   8'd0};
         SEG_YELLOW_GREEN: base_in = '{down,   8'd255, 8'd0};
         SEG_GREEN_CYAN:   base_in = '{8'd0,   8'd255, quot};
         SEG_CYAN_BLUE:    base_in = '{8'd0,   down,   8'd255};
         SEG_BLUE_MAGENTA: base_in = '{quot,   8'd0,   8'd255};
         SEG_MAGENTA_RED:  base_in = '{8'd255, 8'd0,   down};
         default:          base_in = '{8'd255, 8'd255, 8'd255};
      endcase
   end

   always_ff @(posedge clock) begin
      seg_ff  <= seg_in;
      pos_ff  <= pos_in;
      base_ff <= base_in;
   end

   assign base = base_ff;

endmodule

### hdl/vsfs_sqrt.sv
module vsfs_sqrt
   import vsfs_pkg::*;
#(
   parameter int META_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  logic [META_W-1:0] in_meta,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [META_W-1:0] out_meta
);

   localparam int STAGES = ROOT_W;

   logic                valid_ff [0:STAGES-1];
   logic [ROOT_W+1:0]   rem_ff   [0:STAGES-1];
   logic [ROOT_W-1:0]   root_ff  [0:STAGES-1];
   logic [2*ROOT_W-1:0] src_ff   [0:STAGES-1];
   logic [META_W-1:0]   meta_ff  [0:STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                valid;
      logic [ROOT_W+1:0]   rem, rem_shift, trial;
      logic [ROOT_W-1:0]   root;
      logic [2*ROOT_W-1:0] src;
      logic [META_W-1:0]   meta;
      logic                take;

      if (k == 0) begin : g_first
         assign valid = in_valid;
         assign rem   = '0;
         assign root  = '0;
         assign src   = {in_sum, 16'd0};
         assign meta  = in_meta;
      end else begin : g_next
         assign valid = valid_ff[k-1];
         assign rem   = rem_ff[k-1];
         assign root  = root_ff[k-1];
         assign src   = src_ff[k-1];
         assign meta  = meta_ff[k-1];
      end

      assign rem_shift = {rem[ROOT_W-1:0], src[2*ROOT_W-1:2*ROOT_W-2]};
      assign trial     = {root, 2'b01};
      assign take      = rem_shift >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? rem_shift - trial : rem_shift;
            root_ff[k] <= {root[ROOT_W-2:0], take};
            src_ff[k]  <= {src[2*ROOT_W-3:0], 2'b00};
            meta_ff[k] <= meta;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];

endmodule

### hdl/vsfs_div.sv
module vsfs_div
   import vsfs_pkg::*;
#(
   parameter int META_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic [COORD_W-1:0] divisor,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [META_W-1:0]  in_meta,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_quot,
   output logic [META_W-1:0]  out_meta
);

   localparam int STAGES = NUM_W;

   logic               valid_ff [0:STAGES-1];
   logic [COORD_W-1:0] rem_ff   [0:STAGES-1];
   logic [NUM_W-1:0]   dq_ff    [0:STAGES-1];
   logic [META_W-1:0]  meta_ff  [0:STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic               valid;
      logic [COORD_W-1:0] rem;
      logic [NUM_W-1:0]   dq;
      logic [META_W-1:0]  meta;
      logic [COORD_W:0]   part, diff;
      logic               take;

      if (k == 0) begin : g_first
         assign valid = in_valid;
         assign rem   = '0;
         assign dq    = in_num;
         assign meta  = in_meta;
      end else begin : g_next
         assign valid = valid_ff[k-1];
         assign rem   = rem_ff[k-1];
         assign dq    = dq_ff[k-1];
         assign meta  = meta_ff[k-1];
      end

      assign part = {rem, dq[NUM_W-1]};
      assign take = part >= {1'b0, divisor};
      assign diff = part - {1'b0, divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? diff[COORD_W-1:0] : part[COORD_W-1:0];
            dq_ff[k]   <= {dq[NUM_W-2:0], take};
            meta_ff[k] <= meta;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = dq_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];

endmodule

### hdl/voxel_sphere_falloff_shader_core.sv
// Voxel sphere falloff shader core.
// The request channel carries one voxel per transfer: an action (shade or clear),
// the voxel coordinates and the strip and pixel address. The response channel
// returns one transfer per request, in order: inside flag, written flag and the
// scaled red, green and blue intensities.
// A new request is taken every cycle while req_stall is low; the rate is then one
// voxel per cycle, set by the 16-stage square root and the 23-stage divider, which
// both take one item per cycle, and by the single framebuffer memory port pair.
// When the response side stalls with a response waiting, the whole pipeline
// holds and req_stall rises in the same cycle.
// After reset the framebuffer is swept to black, one entry per cycle, over all
// STRIP_COUNT * PIXELS_PER_STRIP entries; req_stall stays high during the sweep.
// Registers written through the csr port are taken at once; write them only
// while no request is in flight.
module voxel_sphere_falloff_shader_core
   import vsfs_pkg::*;
#(
   parameter int STRIP_COUNT      = STRIP_COUNT_DEF,
   parameter int PIXELS_PER_STRIP = PIXELS_PER_STRIP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [COORD_W-1:0]     req_voxel_x,
   input  logic [COORD_W-1:0]     req_voxel_y,
   input  logic [COORD_W-1:0]     req_voxel_z,
   input  logic [STRIP_W-1:0]     req_strip_id,
   input  logic [COORD_W-1:0]     req_pixel_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_inside_res,
   output logic                   rsp_written,
   output logic [CH_W-1:0]        rsp_red,
   output logic [CH_W-1:0]        rsp_green,
   output logic [CH_W-1:0]        rsp_blue,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int FB_DEPTH = STRIP_COUNT * PIXELS_PER_STRIP;
   localparam int IDX_W    = $clog2(FB_DEPTH);

   typedef struct packed {
      logic             action;
      logic             inbox;
      logic             addr_ok;
      logic [IDX_W-1:0] idx;
   } meta_type;

   localparam int META_W = $bits(meta_type);

   // Configuration registers.
   logic [COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff, radius_ff;
   logic [TIME_W-1:0]  time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
         time_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CENTER_X:      center_x_ff <= csr_write_data[COORD_W-1:0];
            CSR_CENTER_Y:      center_y_ff <= csr_write_data[COORD_W-1:0];
            CSR_CENTER_Z:      center_z_ff <= csr_write_data[COORD_W-1:0];
            CSR_SPHERE_RADIUS: radius_ff   <= csr_write_data[COORD_W-1:0];
            CSR_ELAPSED_TIME:  time_ff     <= csr_write_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   rgb_type base;

   vsfs_ramp u_ramp (
      .clock        (clock),
      .elapsed_time (time_ff),
      .base         (base)
   );

   // Pipeline control.
   logic clear_ff;
   logic [IDX_W-1:0] clear_idx_ff;
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = clear_ff | ~advance;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clear_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_idx_ff == IDX_W'(FB_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Stage 1: distances per axis and the framebuffer address.
   logic [COORD_W-1:0] dx, dy, dz;
   logic               strip_ok, pixel_ok;
   logic [31:0]        idx_full;
   meta_type           meta_in;

   always_comb begin
      dx = (req_voxel_x > center_x_ff) ? req_voxel_x - center_x_ff : center_x_ff - req_voxel_x;
      dy = (req_voxel_y > center_y_ff) ? req_voxel_y - center_y_ff : center_y_ff - req_voxel_y;
      dz = (req_voxel_z > center_z_ff) ? req_voxel_z - center_z_ff : center_z_ff - req_voxel_z;
      strip_ok = (req_strip_id >= 4'd2) &&
                 ((32'(req_strip_id) - 32'd2) < 32'(STRIP_COUNT));
      pixel_ok = 32'(req_pixel_index) < 32'(PIXELS_PER_STRIP);
      idx_full = (32'(req_strip_id) - 32'd2) * 32'(PIXELS_PER_STRIP) +
                 32'(req_pixel_index);
      meta_in.action  = req_action;
      meta_in.inbox   = (dx < radius_ff) && (dy < radius_ff) && (dz < radius_ff);
      meta_in.addr_ok = strip_ok && pixel_ok;
      meta_in.idx     = (strip_ok && pixel_ok) ? idx_full[IDX_W-1:0] : '0;
   end

   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   meta_type           s1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff   <= dx;
         s1_dy_ff   <= dy;
         s1_dz_ff   <= dz;
         s1_meta_ff <= meta_in;
      end
   end

   // Stage 2: sum of squares.
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   meta_type         s2_meta_ff;
   logic [13:0]      sq_x, sq_y, sq_z;

   assign sq_x = 14'(s1_dx_ff) * 14'(s1_dx_ff);
   assign sq_y = 14'(s1_dy_ff) * 14'(s1_dy_ff);
   assign sq_z = 14'(s1_dz_ff) * 14'(s1_dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff  <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
         s2_meta_ff <= s1_meta_ff;
      end
   end

   // Distance with 8 fraction bits.
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [META_W-1:0] sq_meta_bits;
   meta_type          sq_meta;

   vsfs_sqrt #(.META_W(META_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s2_valid_ff),
      .in_sum    (s2_sum_ff),
      .in_meta   (s2_meta_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_meta  (sq_meta_bits)
   );

   assign sq_meta = meta_type'(sq_meta_bits);

   // Numerator of the scale; zero for clear actions, voxels outside the box and voxels at or beyond the radius.
   logic [NUM_W:0]   rad_q, dist_q;
   logic [NUM_W-1:0] num;

   always_comb begin
      rad_q  = {1'b0, radius_ff, 16'd0};
      dist_q = {sq_root, 8'd0};
      if (sq_meta.action || !sq_meta.inbox || (dist_q >= rad_q)) begin
         num = '0;
      end else begin
         num = NUM_W'(rad_q - dist_q);
      end
   end

   logic              dv_valid;
   logic [NUM_W-1:0]  dv_quot;
   logic [META_W-1:0] dv_meta_bits;
   meta_type          dv_meta;

   vsfs_div #(.META_W(META_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .divisor   (radius_ff),
      .in_valid  (sq_valid),
      .in_num    (num),
      .in_meta   (sq_meta),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_meta  (dv_meta_bits)
   );

   assign dv_meta = meta_type'(dv_meta_bits);

   // Colour scaling; the framebuffer read is issued in the same cycle.
   // A zero radius never passes the box test, so the divider output is ignored there.
   logic [SCALE_W-1:0]      scale;
   logic [SCALE_W+CH_W-1:0] prod_r, prod_g, prod_b;

   assign scale  = (dv_meta.inbox && !dv_meta.action) ? dv_quot[SCALE_W-1:0] : '0;
   assign prod_r = (SCALE_W+CH_W)'(scale) * (SCALE_W+CH_W)'(base.red);
   assign prod_g = (SCALE_W+CH_W)'(scale) * (SCALE_W+CH_W)'(base.green);
   assign prod_b = (SCALE_W+CH_W)'(scale) * (SCALE_W+CH_W)'(base.blue);

   logic     p_valid_ff;
   logic     p_inside_ff;
   rgb_type  p_colour_ff;
   meta_type p_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_inside_ff <= scale != '0;
         p_colour_ff <= '{prod_r[23:16], prod_g[23:16], prod_b[23:16]};
         p_meta_ff   <= dv_meta;
      end
   end

   // Framebuffer read, modify and write with forwarding of the previous write.
   logic [COLOUR_W-1:0] fb_rd_data, cur_colour, fb_wr_data, upd_data;
   logic                fb_wr_en, upd;
   logic [IDX_W-1:0]    fb_wr_addr;
   logic                last_valid_ff;
   logic [IDX_W-1:0]    last_idx_ff;
   logic [COLOUR_W-1:0] last_data_ff;

   always_comb begin
      cur_colour = (last_valid_ff && (last_idx_ff == p_meta_ff.idx)) ? last_data_ff : fb_rd_data;
      if (p_meta_ff.action) begin
         upd      = p_valid_ff && p_meta_ff.addr_ok;
         upd_data = '0;
      end else begin
         upd      = p_valid_ff && p_inside_ff && p_meta_ff.addr_ok && (cur_colour == '0);
         upd_data = p_colour_ff;
      end
      if (clear_ff) begin
         fb_wr_en   = 1'b1;
         fb_wr_addr = clear_idx_ff;
         fb_wr_data = '0;
      end else begin
         fb_wr_en   = advance && upd;
         fb_wr_addr = p_meta_ff.idx;
         fb_wr_data = upd_data;
      end
   end

   vsfs_ram #(.WIDTH(COLOUR_W), .DEPTH(FB_DEPTH)) u_fb (
      .clock   (clock),
      .wr_en   (fb_wr_en),
      .wr_addr (fb_wr_addr),
      .wr_data (fb_wr_data),
      .rd_en   (advance),
      .rd_addr (dv_meta.idx),
      .rd_data (fb_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else if (advance) begin
         last_valid_ff <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_idx_ff  <= p_meta_ff.idx;
         last_data_ff <= upd_data;
      end
   end

   // Response register.
   logic    rsp_inside_ff, rsp_written_ff;
   rgb_type rsp_colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_inside_ff  <= p_inside_ff;
         rsp_written_ff <= upd;
         rsp_colour_ff  <= p_colour_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_written    = rsp_written_ff;
   assign rsp_red        = rsp_colour_ff.red;
   assign rsp_green      = rsp_colour_ff.green;
   assign rsp_blue       = rsp_colour_ff.blue;

endmodule
